>>> hw/rtl/pfl_pkg.sv
// Package for the page replacement unit: sizes, codes, shared types and helpers.
// It has no dependencies. Every other file in hw/rtl refers to it by scoped names.
package pfl_pkg;

	// Sizes of the frame set and of the beat fields.
	localparam int MAX_FRAMES   = 16;
	localparam int PAGE_BITS    = 16;
	localparam int PAGE_W       = 16;
	localparam int CNT_W        = 32;
	localparam int POLICY_W     = 1;
	localparam int FRAMES_CFG_W = 5;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 5;
	localparam int ACT_W        = $clog2(MAX_FRAMES + 1);
	localparam int IDX_W        = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

	localparam logic [CNT_W-1:0]        CNT_MAX      = {CNT_W{1'b1}};
	localparam logic [PAGE_W-1:0]       PAGE_MASK    = PAGE_W'((64'd1 << PAGE_BITS) - 64'd1);
	localparam logic [FRAMES_CFG_W-1:0] FRAMES_RESET = FRAMES_CFG_W'(16);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = CFG_IDX_W'(1);

	// Input beat kinds and replacement policies.
	localparam logic KIND_REF    = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;
	localparam logic POLICY_FIFO = 1'b0;
	localparam logic POLICY_LRU  = 1'b1;

	// Outcome of one lookup in the frame set.
	typedef struct packed {
		logic              hit;
		logic              evicted_valid;
		logic [PAGE_W-1:0] evicted_page;
	} lookup_t;

	// Control from the pipeline to the counters.
	typedef struct packed {
		logic step;
		logic clear;
		logic hit;
	} count_ctl_t;

	// Counter values after the current beat.
	typedef struct packed {
		logic [CNT_W-1:0] fault_count;
		logic [CNT_W-1:0] hit_count;
		logic [CNT_W-1:0] access_count;
	} counts_t;

	// Increment that sticks at the top of the range.
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
	endfunction

endpackage

>>> hw/rtl/pfl_req_if.sv
// Request channel of the page replacement unit: valid, ready and the reference beat.
// Depends on pfl_pkg for the field widths.
interface pfl_req_if;
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic [pfl_pkg::PAGE_W-1:0] page;

	modport source (output valid, output kind, output page, input ready);
	modport sink   (input valid, input kind, input page, output ready);
endinterface

>>> hw/rtl/pfl_rsp_if.sv
// Response channel of the page replacement unit: valid, ready and the result beat.
// Depends on pfl_pkg for the field widths.
interface pfl_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       hit;
	logic                       evicted_valid;
	logic [pfl_pkg::PAGE_W-1:0] evicted_page;
	logic [pfl_pkg::CNT_W-1:0]  fault_count;
	logic [pfl_pkg::CNT_W-1:0]  hit_count;
	logic [pfl_pkg::CNT_W-1:0]  access_count;

	modport source (output valid, output hit, output evicted_valid, output evicted_page,
		output fault_count, output hit_count, output access_count, input ready);
	modport sink   (input valid, input hit, input evicted_valid, input evicted_page,
		input fault_count, input hit_count, input access_count, output ready);
endinterface

>>> hw/rtl/pfl_frames.sv
// Frame set of the page replacement unit: stored pages, valid bits, parallel compare
// and the shift that retires the oldest or hit frame. Depends on pfl_pkg.
module pfl_frames (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step,
	input  logic                               clear,
	input  logic [pfl_pkg::PAGE_W-1:0]         page,
	input  logic                               policy,
	input  logic [pfl_pkg::ACT_W-1:0]          active,
	output pfl_pkg::lookup_t                   lookup
);

	logic [pfl_pkg::PAGE_W-1:0] page_q  [pfl_pkg::MAX_FRAMES];
	logic [pfl_pkg::PAGE_W-1:0] page_d  [pfl_pkg::MAX_FRAMES];
	logic [pfl_pkg::MAX_FRAMES-1:0] valid_q;
	logic [pfl_pkg::MAX_FRAMES-1:0] valid_d;
	logic [pfl_pkg::MAX_FRAMES-1:0] match;
	logic [pfl_pkg::PAGE_W-1:0] page_m;
	logic [pfl_pkg::IDX_W-1:0]  hit_idx;
	logic [pfl_pkg::IDX_W-1:0]  from_idx;
	logic [pfl_pkg::IDX_W-1:0]  top_idx;
	logic                       hit;
	logic                       move;

	assign page_m  = page & pfl_pkg::PAGE_MASK;
	assign top_idx = pfl_pkg::IDX_W'(active - pfl_pkg::ACT_W'(1));

	// Compare against every valid frame below the active count.
	always_comb begin
		for (int k = 0; k < pfl_pkg::MAX_FRAMES; k++) begin
			match[k] = valid_q[k] && (page_q[k] == page_m) && (k < int'(active));
		end
	end

	// The lowest matching position wins.
	always_comb begin
		hit_idx = '0;
		for (int k = pfl_pkg::MAX_FRAMES - 1; k >= 0; k--) begin
			if (match[k]) begin
				hit_idx = pfl_pkg::IDX_W'(k);
			end
		end
	end

	assign hit      = |match;
	assign move     = !hit || (policy == pfl_pkg::POLICY_LRU);
	assign from_idx = hit ? hit_idx : '0;

	// Next frame contents: shift down above the removed position, new page on top.
	always_comb begin
		for (int k = 0; k < pfl_pkg::MAX_FRAMES; k++) begin
			page_d[k]  = page_q[k];
			valid_d[k] = valid_q[k];
			if (clear) begin
				valid_d[k] = 1'b0;
			end else if (step && move && (k >= int'(from_idx))) begin
				if (k < int'(top_idx)) begin
					if (k < pfl_pkg::MAX_FRAMES - 1) begin
						page_d[k]  = page_q[(k < pfl_pkg::MAX_FRAMES - 1) ? k + 1 : k];
						valid_d[k] = valid_q[(k < pfl_pkg::MAX_FRAMES - 1) ? k + 1 : k];
					end
				end else if (k == int'(top_idx)) begin
					page_d[k]  = page_m;
					valid_d[k] = 1'b1;
				end
			end
		end
	end

	// Valid bits are cleared by reset; the pages themselves are only read when valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < pfl_pkg::MAX_FRAMES; k++) begin
			page_q[k] <= page_d[k];
		end
	end

	// On a fault the oldest frame leaves, if it held a page.
	always_comb begin
		lookup.hit           = step && hit;
		lookup.evicted_valid = step && !hit && valid_q[0];
		lookup.evicted_page  = lookup.evicted_valid ? page_q[0] : '0;
	end

endmodule

>>> hw/rtl/pfl_counters.sv
// Saturating fault, hit and reference counters of the page replacement unit.
// Depends on pfl_pkg for the counter width and the saturating increment.
module pfl_counters (
	input  logic                clk,
	input  logic                arst_n,
	input  pfl_pkg::count_ctl_t ctl,
	output pfl_pkg::counts_t    counts
);

	pfl_pkg::counts_t counts_q;
	pfl_pkg::counts_t counts_d;

	// Values after this beat; they also form the result fields.
	always_comb begin
		counts_d = counts_q;
		if (ctl.clear) begin
			counts_d = '0;
		end else if (ctl.step) begin
			counts_d.access_count = pfl_pkg::sat_inc(counts_q.access_count);
			if (ctl.hit) begin
				counts_d.hit_count = pfl_pkg::sat_inc(counts_q.hit_count);
			end else begin
				counts_d.fault_count = pfl_pkg::sat_inc(counts_q.fault_count);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counts_q <= '0;
		end else begin
			counts_q <= counts_d;
		end
	end

	assign counts = counts_d;

endmodule

>>> hw/rtl/page_replacement_fifo_lru_unit.sv
// Page replacement unit, FIFO or LRU, over a fully associative frame set.
// Results: each beat passes the input register, then the result register, which holds it until taken.
// Throughput: one request per cycle while results drain; the compare and shift of all frames fit in one stage.
// Reset: all frames empty, all counters zero, policy FIFO, sixteen frames in use.
// Depends on pfl_pkg, pfl_req_if, pfl_rsp_if, pfl_frames and pfl_counters.
module page_replacement_fifo_lru_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	pfl_req_if.sink                           req,
	pfl_rsp_if.source                         rsp,
	input  logic                              cfg_we,
	input  logic [pfl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pfl_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic                                policy_q;
	logic [pfl_pkg::FRAMES_CFG_W-1:0]    frames_q;
	logic [pfl_pkg::ACT_W-1:0]           active;

	logic                                valid_s1;
	logic                                kind_s1;
	logic [pfl_pkg::PAGE_W-1:0]          page_s1;
	logic                                valid_s2;
	pfl_pkg::lookup_t                    lookup_s2;
	pfl_pkg::counts_t                    counts_s2;

	logic                                advance;
	pfl_pkg::lookup_t                    lookup;
	pfl_pkg::counts_t                    counts;
	pfl_pkg::count_ctl_t                 ctl;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= pfl_pkg::POLICY_FIFO;
			frames_q <= pfl_pkg::FRAMES_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pfl_pkg::CFG_POLICY_MODE:   policy_q <= cfg_data[0];
				pfl_pkg::CFG_FRAMES_IN_USE: frames_q <= cfg_data[pfl_pkg::FRAMES_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Frame count clamped to one .. MAX_FRAMES.
	always_comb begin
		if (frames_q == '0) begin
			active = pfl_pkg::ACT_W'(1);
		end else if (int'(frames_q) > pfl_pkg::MAX_FRAMES) begin
			active = pfl_pkg::ACT_W'(pfl_pkg::MAX_FRAMES);
		end else begin
			active = pfl_pkg::ACT_W'(frames_q);
		end
	end

	// The work stage moves on when the result register is free or being emptied.
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			kind_s1 <= req.kind;
			page_s1 <= req.page;
		end
	end

	// Frame set and counters update as the beat leaves the input register.
	assign ctl.step  = advance && (kind_s1 == pfl_pkg::KIND_REF);
	assign ctl.clear = advance && (kind_s1 == pfl_pkg::KIND_CLEAR);
	assign ctl.hit   = lookup.hit;

	pfl_frames u_frames (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (ctl.step),
		.clear  (ctl.clear),
		.page   (page_s1),
		.policy (policy_q),
		.active (active),
		.lookup (lookup)
	);

	pfl_counters u_counters (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.counts (counts)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || rsp.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			lookup_s2 <= lookup;
			counts_s2 <= counts;
		end
	end

	assign rsp.valid         = valid_s2;
	assign rsp.hit           = lookup_s2.hit;
	assign rsp.evicted_valid = lookup_s2.evicted_valid;
	assign rsp.evicted_page  = lookup_s2.evicted_page;
	assign rsp.fault_count   = counts_s2.fault_count;
	assign rsp.hit_count     = counts_s2.hit_count;
	assign rsp.access_count  = counts_s2.access_count;

endmodule

>>> test/page_replacement_fifo_lru_unit_test.sv
`timescale 1ns / 100ps
// Self-checking bench for page_replacement_fifo_lru_unit: directed and random page references
// under FIFO and LRU policies and various frame counts, each result predicted and compared.
// Depends on pfl_pkg, pfl_req_if, pfl_rsp_if and the unit itself.
module page_replacement_fifo_lru_unit_test;
	import pfl_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int CHUNKS      = 16;
	localparam int CHUNK_BEATS = 50;

	typedef struct packed {
		logic              kind;
		logic [PAGE_W-1:0] page;
	} page_request_t;

	typedef struct packed {
		logic              hit;
		logic              evicted_valid;
		logic [PAGE_W-1:0] evicted_page;
		logic [CNT_W-1:0]  fault_count;
		logic [CNT_W-1:0]  hit_count;
		logic [CNT_W-1:0]  access_count;
	} page_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pfl_req_if req_ch ();
	pfl_rsp_if rsp_ch ();

	page_replacement_fifo_lru_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Beats waiting to be offered, and results that accepted beats still owe.
	page_request_t page_requests [$];
	page_result_t  owed_results [$];

	// Shadow copy of the frame set, the counters and the registers.
	logic [PAGE_W-1:0]       resident_page [MAX_FRAMES];
	logic                    resident_valid [MAX_FRAMES];
	logic [CNT_W-1:0]        n_faults;
	logic [CNT_W-1:0]        n_hits;
	logic [CNT_W-1:0]        n_refs;
	logic                    policy_now;
	logic [FRAMES_CFG_W-1:0] frames_now;

	int sender_idle_pct;
	int receiver_idle_pct;
	int hold_request;
	int stall_left;
	int error_count;
	int cycle_count;

	logic [FRAMES_CFG_W-1:0] frames_plan [CHUNKS] =
		'{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd8, 5'd2, 5'd4,
		  5'd16, 5'd3, 5'd12, 5'd1, 5'd16, 5'd5, 5'd9, 5'd31};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Take a frame out of its position, close the gap and put the page at the newest end.
	function automatic void promote_frame(input int from, input int top,
			input logic [PAGE_W-1:0] pg);
		for (int k = from; k < top; k++) begin
			resident_page[k]  = resident_page[k + 1];
			resident_valid[k] = resident_valid[k + 1];
		end
		resident_page[top]  = pg;
		resident_valid[top] = 1'b1;
	endfunction

	// Work out the result of one accepted beat and advance the shadow state.
	function automatic page_result_t predict_page_result(input page_request_t rq);
		page_result_t      res;
		int                f;
		int                idx;
		bit                found;
		logic [PAGE_W-1:0] pg;
		res = '0;
		if (rq.kind == KIND_CLEAR) begin
			for (int k = 0; k < MAX_FRAMES; k++) begin
				resident_page[k]  = '0;
				resident_valid[k] = 1'b0;
			end
			n_faults = '0;
			n_hits   = '0;
			n_refs   = '0;
		end else begin
			pg = rq.page & PAGE_MASK;
			f  = int'(frames_now);
			if (f < 1) f = 1;
			if (f > MAX_FRAMES) f = MAX_FRAMES;
			found = 1'b0;
			idx   = 0;
			for (int k = 0; k < f; k++) begin
				if (!found && resident_valid[k] && resident_page[k] == pg) begin
					found = 1'b1;
					idx   = k;
				end
			end
			if (n_refs != CNT_MAX) n_refs++;
			if (found) begin
				res.hit = 1'b1;
				if (n_hits != CNT_MAX) n_hits++;
				if (policy_now == POLICY_LRU) promote_frame(idx, f - 1, pg);
			end else begin
				if (n_faults != CNT_MAX) n_faults++;
				if (resident_valid[0]) begin
					res.evicted_valid = 1'b1;
					res.evicted_page  = resident_page[0];
				end
				promote_frame(0, f - 1, pg);
			end
		end
		res.fault_count  = n_faults;
		res.hit_count    = n_hits;
		res.access_count = n_refs;
		return res;
	endfunction

	task automatic flag_error(input string what, input logic [CNT_W-1:0] want,
			input logic [CNT_W-1:0] got);
		error_count++;
		if (error_count <= 10)
			$display("mismatch on %s at %0t: expected %0h, got %0h", what, $time, want, got);
	endtask

	// Request driver: holds a beat until it is taken, then predicts its result.
	always @(posedge clk) begin : request_driver
		bit holding;
		if (arst_n) begin
			holding = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				owed_results.insert(owed_results.size(),
					predict_page_result(page_requests[0]));
				void'(page_requests.pop_front());
				holding = 1'b0;
			end
			if (!holding) begin
				if (page_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					req_ch.valid <= 1'b1;
					req_ch.kind  <= page_requests[0].kind;
					req_ch.page  <= page_requests[0].page;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Response ready: random stalls, plus a long hold-off when one is requested.
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_request != 0) begin
				stall_left   = hold_request;
				hold_request = 0;
			end
			if (stall_left != 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
			end
		end
	end

	// Result monitor: each accepted beat is checked against the oldest owed result.
	always @(posedge clk) begin : result_monitor
		page_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (owed_results.size() == 0) begin
				flag_error("result beat with nothing owed", 0, 1);
			end else begin
				want = owed_results.pop_front();
				if (rsp_ch.hit !== want.hit)
					flag_error("hit", CNT_W'(want.hit), CNT_W'(rsp_ch.hit));
				if (rsp_ch.evicted_valid !== want.evicted_valid)
					flag_error("evicted_valid", CNT_W'(want.evicted_valid),
						CNT_W'(rsp_ch.evicted_valid));
				if (rsp_ch.evicted_page !== want.evicted_page)
					flag_error("evicted_page", CNT_W'(want.evicted_page),
						CNT_W'(rsp_ch.evicted_page));
				if (rsp_ch.fault_count !== want.fault_count)
					flag_error("fault_count", want.fault_count, rsp_ch.fault_count);
				if (rsp_ch.hit_count !== want.hit_count)
					flag_error("hit_count", want.hit_count, rsp_ch.hit_count);
				if (rsp_ch.access_count !== want.access_count)
					flag_error("access_count", want.access_count, rsp_ch.access_count);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("page_replacement_fifo_lru_unit_test failed");
			$finish;
		end
	end

	task automatic queue_beat(input logic kind, input logic [PAGE_W-1:0] page);
		page_request_t rq;
		rq.kind = kind;
		rq.page = page;
		page_requests.insert(page_requests.size(), rq);
	endtask

	// Wait until every beat is taken and every result has come back.
	task automatic wait_drained();
		do @(negedge clk);
		while (page_requests.size() != 0 || req_ch.valid || owed_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// Write both registers while the unit is idle, and mirror them in the shadow copy.
	task automatic set_mode(input logic policy, input logic [FRAMES_CFG_W-1:0] frames);
		@(posedge clk);
		cfg_we     <= 1'b1;
		cfg_index  <= CFG_POLICY_MODE;
		cfg_data   <= CFG_DATA_W'(policy);
		policy_now = policy;
		@(posedge clk);
		cfg_index  <= CFG_FRAMES_IN_USE;
		cfg_data   <= CFG_DATA_W'(frames);
		frames_now = frames;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Mostly references drawn from a small pool so that hits happen, with some
	// pages drawn from the whole range and the odd clear.
	task automatic fill_random(input int count);
		int                pool;
		int                roll;
		logic [PAGE_W-1:0] base;
		pool = $urandom_range(24, 1);
		base = PAGE_W'($urandom);
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(99);
			if (roll < 3)
				queue_beat(KIND_CLEAR, PAGE_W'($urandom));
			else if (roll < 13)
				queue_beat(KIND_REF, PAGE_W'($urandom));
			else
				queue_beat(KIND_REF, base + PAGE_W'($urandom_range(pool - 1)));
		end
	endtask

	initial begin
		req_ch.valid      = 1'b0;
		req_ch.kind       = KIND_REF;
		req_ch.page       = '0;
		rsp_ch.ready      = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = CFG_POLICY_MODE;
		cfg_data          = '0;
		arst_n            = 1'b0;
		sender_idle_pct   = 6;
		receiver_idle_pct = 84;
		hold_request      = 0;
		stall_left        = 0;
		error_count       = 0;
		cycle_count       = 0;
		policy_now        = POLICY_FIFO;
		frames_now        = FRAMES_RESET;
		n_faults          = '0;
		n_hits            = '0;
		n_refs            = '0;
		for (int k = 0; k < MAX_FRAMES; k++) begin
			resident_page[k]  = '0;
			resident_valid[k] = 1'b0;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: empty frames must not hit, not even on page zero; clear restarts all.
		queue_beat(KIND_REF, 16'h0000);
		queue_beat(KIND_REF, 16'hFFFF);
		queue_beat(KIND_REF, 16'h0000);
		queue_beat(KIND_REF, 16'hFFFF);
		queue_beat(KIND_CLEAR, 16'hFFFF);
		queue_beat(KIND_REF, 16'h0000);
		wait_drained();

		// Two frames under LRU: a hit moves the page to the newest end.
		set_mode(POLICY_LRU, 5'd2);
		queue_beat(KIND_REF, 16'h0001);
		queue_beat(KIND_REF, 16'h0002);
		queue_beat(KIND_REF, 16'h0001);
		queue_beat(KIND_REF, 16'h0003);
		queue_beat(KIND_REF, 16'h0001);
		queue_beat(KIND_REF, 16'h8000);
		wait_drained();

		// A frame count of zero behaves as a single frame.
		set_mode(POLICY_FIFO, 5'd0);
		queue_beat(KIND_REF, 16'h0007);
		queue_beat(KIND_REF, 16'h0007);
		queue_beat(KIND_REF, 16'h0008);
		wait_drained();

		// An oversized frame count behaves as the full set.
		set_mode(POLICY_LRU, 5'd31);
		queue_beat(KIND_CLEAR, 16'h0000);
		queue_beat(KIND_REF, 16'h0010);
		queue_beat(KIND_REF, 16'h0011);
		queue_beat(KIND_REF, 16'h0012);
		queue_beat(KIND_REF, 16'h0013);
		wait_drained();

		// Shrinking the set leaves the upper frames alone, so a page can become
		// resident twice; the lower copy must win once the set grows again.
		set_mode(POLICY_LRU, 5'd2);
		queue_beat(KIND_REF, 16'h0013);
		wait_drained();
		set_mode(POLICY_LRU, 5'd16);
		queue_beat(KIND_REF, 16'h0013);
		queue_beat(KIND_REF, 16'h0012);
		queue_beat(KIND_REF, 16'h7FFF);
		wait_drained();

		// Random references over a spread of settings and idling patterns.
		for (int c = 0; c < CHUNKS; c++) begin
			if (c == 6) begin
				sender_idle_pct   = 84;
				receiver_idle_pct = 6;
			end else if (c == 12) begin
				sender_idle_pct   = 0;
				receiver_idle_pct = 0;
			end
			set_mode((c % 2 == 1) ^ (c >= 8) ? POLICY_LRU : POLICY_FIFO, frames_plan[c]);
			// The receiver holds off long enough for the unit to back up its input.
			if (c == 13) hold_request = 300;
			fill_random(CHUNK_BEATS);
			wait_drained();
		end

		repeat (10) @(negedge clk);
		if (error_count == 0 && owed_results.size() == 0)
			$display("page_replacement_fifo_lru_unit_test passed");
		else
			$display("page_replacement_fifo_lru_unit_test failed");
		$finish;
	end

endmodule
